/* rtl/core/aecc_pkg.sv */
// Shared types, constants and helpers for the echo / clip / crush core.
// No dependencies; the top level, ring and mix files in rtl/core import this package.
`timescale 1ns / 1ps
`default_nettype none

package aecc_pkg;

    localparam int RING_LENGTH = 4096;
    localparam int RING_AW     = (RING_LENGTH > 1) ? $clog2(RING_LENGTH) : 1;

    localparam logic [1:0] MODE_DIST  = 2'd0;
    localparam logic [1:0] MODE_CRUSH = 2'd1;

    localparam logic [2:0] CFG_EFFECT_MODE = 3'd0;
    localparam logic [2:0] CFG_DRIVE_GAIN  = 3'd1;
    localparam logic [2:0] CFG_CLIP_LEVEL  = 3'd2;
    localparam logic [2:0] CFG_CRUSH_BITS  = 3'd3;
    localparam logic [2:0] CFG_ECHO_LAG    = 3'd4;
    localparam logic [2:0] CFG_ECHO_GAIN   = 3'd5;

    localparam logic signed [31:0] SAT_MAX = 32'sd32767;
    localparam logic signed [31:0] SAT_MIN = -32'sd32768;
    localparam int                 Q_SHIFT = 15;

    typedef struct packed {
        logic [1:0]         effect_mode;
        logic [7:0]         drive_gain;
        logic [14:0]        clip_level;
        logic [4:0]         crush_bits;
        logic [15:0]        echo_lag;
        logic signed [15:0] echo_gain;
    } t_cfg;

    // pipeline advance strobes
    typedef struct packed {
        logic accept;
        logic move1;
        logic move2;
    } t_ctl;

    // stage 0 contents: captured item plus ring read result
    typedef struct packed {
        logic signed [15:0] sample;
        logic [1:0]         mode;
        logic               eob;
        logic [1:0]         keep;
        logic signed [15:0] dly;
        logic               hit;
    } t_s0;

    function automatic logic is_echo(input logic [1:0] mode);
        return (mode != MODE_DIST) && (mode != MODE_CRUSH);
    endfunction

endpackage

`default_nettype wire

/* rtl/core/audio_effect_echo_clip_crush_core.sv */
// Top level of the echo / clip / crush audio core: config registers,
// pipeline control and the ring and mix stages. Depends on aecc_pkg,
// aecc_ring and aecc_mix.
//
//   channel   direction  handshake             payload
//   input     in         i_valid / o_ready     i_sample_in, i_end_of_block, i_byte_keep
//   output    out        o_valid / i_ready     o_sample_out, o_end_of_block_out,
//                                              o_byte_keep_out
//   config    in         i_cfg_we              i_cfg_idx, i_cfg_data
//
// One sample per cycle sustained while the output is not stalled; a result passes through three
// registers after its input transfer: ring memory read, multiplier register, output register.
// Reset clears the control state, the ring head and the fill count; the ring needs no
// clearing pass, since the fill count marks entries never written and those read as zero.
// Each stage holds while the one after it is full and stalled, so an empty stage
// downstream still takes a transfer while a result waits on the output.
`timescale 1ns / 1ps
`default_nettype none

module audio_effect_echo_clip_crush_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [15:0] i_sample_in,
    input  logic               i_end_of_block,
    input  logic [1:0]         i_byte_keep,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_sample_out,
    output logic               o_end_of_block_out,
    output logic [1:0]         o_byte_keep_out
);
    import aecc_pkg::*;

    t_cfg r_cfg;
    t_ctl w_ctl;
    t_s0  w_s0;

    logic r_v0, r_v1, r_v2;
    logic w_rdy1, w_rdy2;

    // configuration registers; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.effect_mode <= MODE_DIST;
            r_cfg.drive_gain  <= 8'd1;
            r_cfg.clip_level  <= 15'h7FFF;
            r_cfg.crush_bits  <= 5'd0;
            r_cfg.echo_lag    <= 16'd0;
            r_cfg.echo_gain   <= 16'sd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_EFFECT_MODE: r_cfg.effect_mode <= i_cfg_data[1:0];
                CFG_DRIVE_GAIN:  r_cfg.drive_gain  <= i_cfg_data[7:0];
                CFG_CLIP_LEVEL:  r_cfg.clip_level  <= i_cfg_data[14:0];
                CFG_CRUSH_BITS:  r_cfg.crush_bits  <= i_cfg_data[4:0];
                CFG_ECHO_LAG:    r_cfg.echo_lag    <= i_cfg_data;
                CFG_ECHO_GAIN:   r_cfg.echo_gain   <= $signed(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    // advance a stage when the next one is empty or moving on itself
    always_comb begin
        w_rdy2       = !r_v2 || i_ready;
        w_rdy1       = !r_v1 || w_rdy2;
        w_ctl.move2  = r_v1 && w_rdy2;
        w_ctl.move1  = r_v0 && w_rdy1;
        o_ready      = !r_v0 || w_rdy1;
        w_ctl.accept = i_valid && o_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_ctl.accept) begin
                r_v0 <= 1'b1;
            end else if (w_ctl.move1) begin
                r_v0 <= 1'b0;
            end
            if (w_ctl.move1) begin
                r_v1 <= 1'b1;
            end else if (w_ctl.move2) begin
                r_v1 <= 1'b0;
            end
            if (w_ctl.move2) begin
                r_v2 <= 1'b1;
            end else if (i_ready) begin
                r_v2 <= 1'b0;
            end
        end
    end

    assign o_valid = r_v2;

    // stage 0: ring read at the lag address, dry sample written at the head in echo mode
    aecc_ring u_ring (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_ctl    (w_ctl),
        .i_sample (i_sample_in),
        .i_eob    (i_end_of_block),
        .i_keep   (i_byte_keep),
        .o_s0     (w_s0)
    );

    // stages 1 and 2: multiply, then clip, crush or mix and saturate
    aecc_mix u_mix (
        .i_clk    (i_clk),
        .i_cfg    (r_cfg),
        .i_ctl    (w_ctl),
        .i_s0     (w_s0),
        .o_sample (o_sample_out),
        .o_eob    (o_end_of_block_out),
        .o_keep   (o_byte_keep_out)
    );

endmodule

`default_nettype wire

/* rtl/core/aecc_ring.sv */
// Delay ring: sample memory, write head, fill count and lag address.
// Depends on aecc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module aecc_ring (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  aecc_pkg::t_cfg     i_cfg,
    input  aecc_pkg::t_ctl     i_ctl,
    input  logic signed [15:0] i_sample,
    input  logic               i_eob,
    input  logic [1:0]         i_keep,
    output aecc_pkg::t_s0      o_s0
);
    import aecc_pkg::*;

    logic signed [15:0] r_mem [RING_LENGTH];
    logic signed [15:0] r_rd_data;
    logic               r_hit;
    logic [RING_AW-1:0] r_head, n_head;
    logic [RING_AW:0]   r_fill, n_fill;
    logic signed [15:0] r_sample;
    logic [1:0]         r_mode;
    logic               r_eob;
    logic [1:0]         r_keep;

    logic [RING_AW-1:0] w_lag;
    logic [RING_AW-1:0] w_idx;
    logic               w_echo;

    always_comb begin
        if (32'(i_cfg.echo_lag) >= RING_LENGTH) begin
            w_lag = RING_AW'(RING_LENGTH - 1);
        end else begin
            w_lag = RING_AW'(i_cfg.echo_lag);
        end
        if (r_head >= w_lag) begin
            w_idx = r_head - w_lag;
        end else begin
            w_idx = RING_AW'((RING_AW+1)'(r_head) + (RING_AW+1)'(RING_LENGTH)
                             - (RING_AW+1)'(w_lag));
        end
        w_echo = is_echo(i_cfg.effect_mode);
        n_head = r_head;
        n_fill = r_fill;
        if (i_ctl.accept && w_echo) begin
            n_head = ((RING_AW+1)'(r_head) + 1'b1 == (RING_AW+1)'(RING_LENGTH))
                     ? '0 : r_head + 1'b1;
            if (r_fill != (RING_AW+1)'(RING_LENGTH)) begin
                n_fill = r_fill + 1'b1;
            end
        end
    end

    // read before write: zero lag sees the old entry at the head
    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_rd_data <= r_mem[w_idx];
            if (w_echo) begin
                r_mem[r_head] <= i_sample;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_fill <= '0;
        end else begin
            r_head <= n_head;
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_hit    <= ((RING_AW+1)'(w_idx) < r_fill);
            r_sample <= i_sample;
            r_mode   <= i_cfg.effect_mode;
            r_eob    <= i_eob;
            r_keep   <= i_keep;
        end
    end

    assign o_s0.sample = r_sample;
    assign o_s0.mode   = r_mode;
    assign o_s0.eob    = r_eob;
    assign o_s0.keep   = r_keep;
    assign o_s0.dly    = r_hit ? r_rd_data : 16'sd0;
    assign o_s0.hit    = r_hit;

endmodule

`default_nettype wire

/* rtl/core/aecc_mix.sv */
// Shared multiplier stage and final clip / crush / saturate stage.
// Depends on aecc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module aecc_mix (
    input  logic               i_clk,
    input  aecc_pkg::t_cfg     i_cfg,
    input  aecc_pkg::t_ctl     i_ctl,
    input  aecc_pkg::t_s0      i_s0,
    output logic signed [15:0] o_sample,
    output logic               o_eob,
    output logic [1:0]         o_keep
);
    import aecc_pkg::*;

    logic signed [31:0] r1_prod;
    logic signed [15:0] r1_sample;
    logic [1:0]         r1_mode;
    logic               r1_eob;
    logic [1:0]         r1_keep;

    logic signed [16:0] w_opa, w_opb;
    logic signed [33:0] w_mul;
    logic signed [31:0] w_lim, w_mixed;
    logic [15:0]        w_mask;
    logic signed [15:0] w_y;

    // one multiplier: delayed * echo gain, or sample * drive gain
    always_comb begin
        if (is_echo(i_s0.mode)) begin
            w_opa = 17'(i_s0.dly);
            w_opb = 17'(i_cfg.echo_gain);
        end else begin
            w_opa = 17'(i_s0.sample);
            w_opb = $signed({9'd0, i_cfg.drive_gain});
        end
        w_mul = w_opa * w_opb;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.move1) begin
            r1_prod   <= 32'(w_mul);
            r1_sample <= i_s0.sample;
            r1_mode   <= i_s0.mode;
            r1_eob    <= i_s0.eob;
            r1_keep   <= i_s0.keep;
        end
    end

    always_comb begin
        w_lim   = $signed({17'd0, i_cfg.clip_level});
        w_mixed = 32'(r1_sample) + (r1_prod >>> Q_SHIFT);
        w_mask  = (i_cfg.crush_bits >= 5'd16) ? 16'd0 : (16'hFFFF << i_cfg.crush_bits);
        unique case (r1_mode)
            MODE_DIST: begin
                if (r1_prod > w_lim) begin
                    w_y = 16'(w_lim);
                end else if (r1_prod < -w_lim) begin
                    w_y = 16'(-w_lim);
                end else begin
                    w_y = 16'(r1_prod);
                end
            end
            MODE_CRUSH: begin
                w_y = $signed(r1_sample & w_mask);
            end
            default: begin
                if (w_mixed > SAT_MAX) begin
                    w_y = 16'(SAT_MAX);
                end else if (w_mixed < SAT_MIN) begin
                    w_y = 16'(SAT_MIN);
                end else begin
                    w_y = 16'(w_mixed);
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.move2) begin
            o_sample <= w_y;
            o_eob    <= r1_eob;
            o_keep   <= r1_keep;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/aecc_checker.sv */
// Port-level checks for the echo / clip / crush core, bound to the top level.
// Depends on audio_effect_echo_clip_crush_core.
`timescale 1ns / 1ps
`default_nettype none

module aecc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_ready,
    input logic               o_valid,
    input logic               i_ready,
    input logic signed [15:0] o_sample_out,
    input logic               o_end_of_block_out,
    input logic [1:0]         o_byte_keep_out
);
    logic [2:0] r_inflight;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= r_inflight + 3'(i_valid && o_ready) - 3'(o_valid && i_ready);
        end
    end

    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight <= 3'd3)
        else $error("more samples in flight than pipeline stages");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_inflight != 3'd0))
        else $error("result offered with no sample in flight");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_inflight == 3'd3) && !i_ready |-> !o_ready)
        else $error("input taken while every stage is full and stalled");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid straight after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_sample_out)
            && $stable(o_end_of_block_out) && $stable(o_byte_keep_out))
        else $error("stalled result changed");

endmodule

bind audio_effect_echo_clip_crush_core aecc_checker u_aecc_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_valid            (i_valid),
    .o_ready            (o_ready),
    .o_valid            (o_valid),
    .i_ready            (i_ready),
    .o_sample_out       (o_sample_out),
    .o_end_of_block_out (o_end_of_block_out),
    .o_byte_keep_out    (o_byte_keep_out)
);

`default_nettype wire

/* tb/tb.sv */
// Self-checking bench for the echo / clip / crush audio core: directed table, then random
// segments that sweep the settings and the flow-control patterns on both channels.
// Depends on aecc_pkg and audio_effect_echo_clip_crush_core.
`timescale 1ns / 1ps

module tb;
    import aecc_pkg::*;

    // Echo mode codes: anything that is neither distortion nor crush selects echo.
    localparam logic [1:0] MODE_ECHO     = 2'd2;
    localparam logic [1:0] MODE_ECHO_ALT = 2'd3;

    // Register indexes past the last register; writes to them must change nothing.
    localparam logic [2:0] CFG_SPARE_6 = 3'd6;
    localparam logic [2:0] CFG_SPARE_7 = 3'd7;

    localparam int          DIR_ROWS     = 47;
    localparam int unsigned RUN_LIMIT_NS = 5_000_000;

    typedef enum logic {ROW_REG, ROW_SMP} row_kind_t;
    typedef enum logic [1:0] {IDLE_NONE, IDLE_SRC, IDLE_SNK, IDLE_BOTH} idle_mode_t;

    typedef struct packed {
        row_kind_t          kind;
        logic [2:0]         reg_idx;
        logic [15:0]        reg_val;
        logic signed [15:0] smp;
        logic               eob;
        logic [1:0]         keep;
        logic               typed;
        logic signed [15:0] want;
    } step_row_t;

    typedef struct packed {
        logic signed [15:0] smp;
        logic               eob;
        logic [1:0]         keep;
    } processed_t;

    // DUT inputs start at known values.
    logic               i_clk              = 1'b0;
    logic               i_rst_n            = 1'b0;
    logic               i_cfg_we           = 1'b0;
    logic [2:0]         i_cfg_idx          = '0;
    logic [15:0]        i_cfg_data         = '0;
    logic               i_valid            = 1'b0;
    logic signed [15:0] i_sample_in        = '0;
    logic               i_end_of_block     = 1'b0;
    logic [1:0]         i_byte_keep        = '0;
    logic               i_ready            = 1'b0;
    logic               o_ready;
    logic               o_valid;
    logic signed [15:0] o_sample_out;
    logic               o_end_of_block_out;
    logic [1:0]         o_byte_keep_out;

    // Shadow copy of the configuration and of the echo history.
    logic [1:0]         cur_mode       = MODE_DIST;
    logic [7:0]         cur_drive      = 8'd1;
    logic [14:0]        cur_clip       = 15'd32767;
    logic [4:0]         cur_crush      = 5'd0;
    logic [15:0]        cur_lag        = 16'd0;
    logic signed [15:0] cur_echo_gain  = 16'sd0;
    logic signed [15:0] echo_hist [RING_LENGTH];
    int unsigned        hist_head      = 0;

    processed_t  processed_due [$];
    processed_t  got_due;
    step_row_t   dir_table [DIR_ROWS];
    int unsigned gap_pct    = 0;
    int unsigned stall_pct  = 0;
    int unsigned fail_count = 0;

    audio_effect_echo_clip_crush_core u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_sample_in        (i_sample_in),
        .i_end_of_block     (i_end_of_block),
        .i_byte_keep        (i_byte_keep),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_sample_out       (o_sample_out),
        .o_end_of_block_out (o_end_of_block_out),
        .o_byte_keep_out    (o_byte_keep_out)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Hard stop in case a transfer never completes.
    initial begin
        #(RUN_LIMIT_NS);
        $display("TEST FAILED");
        $finish;
    end

    // Work out the processed sample for one accepted transfer; echo mode also
    // records the dry sample and advances the history head.
    function automatic logic signed [15:0] process_sample(input logic signed [15:0] x);
        logic signed [31:0] amp;
        logic signed [31:0] lim;
        logic signed [31:0] prod;
        logic signed [31:0] mix;
        logic [15:0]        mask;
        logic signed [15:0] delayed;
        int unsigned        lag;
        int unsigned        idx;
        if (cur_mode == MODE_DIST) begin
            amp = x * $signed({1'b0, cur_drive});
            lim = $signed({1'b0, cur_clip});
            if (amp > lim) begin
                amp = lim;
            end else if (amp < -lim) begin
                amp = -lim;
            end
            return amp[15:0];
        end else if (cur_mode == MODE_CRUSH) begin
            // sixteen or more clears the whole word
            mask = (cur_crush >= 5'd16) ? 16'h0000 : (16'hFFFF << cur_crush);
            return $signed(x & mask);
        end else begin
            // clamp long lags; lag zero lands on the oldest entry
            lag = (cur_lag >= RING_LENGTH) ? RING_LENGTH - 1 : cur_lag;
            idx = (hist_head >= lag) ? hist_head - lag : hist_head + RING_LENGTH - lag;
            delayed = echo_hist[idx];
            prod = delayed * cur_echo_gain;
            mix = x + (prod >>> Q_SHIFT);
            if (mix > SAT_MAX) begin
                mix = SAT_MAX;
            end else if (mix < SAT_MIN) begin
                mix = SAT_MIN;
            end
            echo_hist[hist_head] = x;
            hist_head = (hist_head + 1 == RING_LENGTH) ? 0 : hist_head + 1;
            return mix[15:0];
        end
    endfunction

    function automatic step_row_t reg_row(input logic [2:0] idx, input logic [15:0] val);
        step_row_t row;
        row = '0;
        row.kind = ROW_REG;
        row.reg_idx = idx;
        row.reg_val = val;
        return row;
    endfunction

    function automatic step_row_t smp_row(input logic signed [15:0] smp, input logic eob,
                                          input logic [1:0] keep, input logic typed,
                                          input logic signed [15:0] want);
        step_row_t row;
        row = '0;
        row.kind = ROW_SMP;
        row.smp = smp;
        row.eob = eob;
        row.keep = keep;
        row.typed = typed;
        row.want = want;
        return row;
    endfunction

    // Write one register and mirror it in the shadow copy. Leaves the write
    // enable high; the next sample transfer drops it.
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_EFFECT_MODE: cur_mode = val[1:0];
            CFG_DRIVE_GAIN:  cur_drive = val[7:0];
            CFG_CLIP_LEVEL:  cur_clip = val[14:0];
            CFG_CRUSH_BITS:  cur_crush = val[4:0];
            CFG_ECHO_LAG:    cur_lag = val;
            CFG_ECHO_GAIN:   cur_echo_gain = $signed(val);
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Drop valid and hold until every outstanding result has been checked.
    task automatic drain_results();
        i_valid <= 1'b0;
        while (processed_due.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Offer one sample, with random gaps beforehand, and hold it until the
    // transfer completes. Returns in the step of the accepting edge.
    task automatic send_sample(input logic signed [15:0] smp, input logic eob,
                               input logic [1:0] keep, input logic typed,
                               input logic signed [15:0] want);
        processed_t         entry;
        logic signed [15:0] predicted;
        i_cfg_we <= 1'b0;
        while ($urandom_range(99) < gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_sample_in    <= smp;
        i_end_of_block <= eob;
        i_byte_keep    <= keep;
        @(posedge i_clk);
        while (!o_ready) begin
            @(posedge i_clk);
        end
        predicted  = process_sample(smp);
        entry.smp  = typed ? want : predicted;
        entry.eob  = eob;
        entry.keep = keep;
        processed_due.push_back(entry);
    endtask

    // One random stretch: pick the flow-control pattern, drain, load fresh
    // settings (extremes favoured, junk above each register's width), then stream.
    task automatic run_segment(input int unsigned n_items, input idle_mode_t idle,
                               input int unsigned kind, input bit wrap_lag);
        logic [1:0]         mode;
        logic [15:0]        lag;
        logic [15:0]        egain;
        logic signed [15:0] smp;
        case (idle)
            IDLE_NONE: begin gap_pct = 0;  stall_pct = 0;  end
            IDLE_SRC:  begin gap_pct = 65; stall_pct = 0;  end
            IDLE_SNK:  begin gap_pct = 0;  stall_pct = 65; end
            default:   begin gap_pct = 16; stall_pct = 16; end
        endcase
        case (kind)
            0:       mode = MODE_DIST;
            1:       mode = MODE_CRUSH;
            default: mode = $urandom_range(1) ? MODE_ECHO : MODE_ECHO_ALT;
        endcase
        case ($urandom_range(5))
            0:       lag = 16'd0;
            1:       lag = 16'd1;
            2:       lag = 16'(RING_LENGTH - 1);
            3:       lag = 16'($urandom_range(65535, RING_LENGTH));
            4:       lag = 16'hFFFF;
            default: lag = 16'($urandom_range(64, 1));
        endcase
        if (wrap_lag) begin
            lag = 16'd0;
        end
        case ($urandom_range(3))
            0:       egain = 16'h8000;
            1:       egain = 16'h7FFF;
            2:       egain = 16'($urandom_range(512)) - 16'd256;
            default: egain = 16'($urandom);
        endcase
        drain_results();
        write_reg(CFG_EFFECT_MODE, {14'($urandom), mode});
        case ($urandom_range(3))
            0:       write_reg(CFG_DRIVE_GAIN, {8'($urandom), 8'd0});
            1:       write_reg(CFG_DRIVE_GAIN, {8'($urandom), 8'd1});
            2:       write_reg(CFG_DRIVE_GAIN, {8'($urandom), 8'd255});
            default: write_reg(CFG_DRIVE_GAIN, 16'($urandom));
        endcase
        case ($urandom_range(3))
            0:       write_reg(CFG_CLIP_LEVEL, {1'($urandom), 15'd0});
            1:       write_reg(CFG_CLIP_LEVEL, {1'($urandom), 15'd32767});
            default: write_reg(CFG_CLIP_LEVEL, 16'($urandom));
        endcase
        write_reg(CFG_CRUSH_BITS, {11'($urandom), 5'($urandom_range(31))});
        write_reg(CFG_ECHO_LAG, lag);
        write_reg(CFG_ECHO_GAIN, egain);
        write_reg($urandom_range(1) ? CFG_SPARE_6 : CFG_SPARE_7, 16'($urandom));
        repeat (n_items) begin
            case ($urandom_range(7))
                0:       smp = 16'sh7FFF;
                1:       smp = 16'sh8000;
                2:       smp = $urandom_range(1) ? 16'sh0000 : 16'shFFFF;
                3:       smp = 16'($urandom_range(255)) - 16'sd128;
                default: smp = 16'($urandom);
            endcase
            send_sample(smp, $urandom_range(15) == 0, 2'($urandom_range(3)), 1'b0, '0);
        end
    endtask

    // Output side: stall at random, and check every completed transfer against
    // the oldest outstanding prediction.
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= stall_pct);
        if (i_rst_n && o_valid && i_ready) begin
            if (processed_due.size() == 0) begin
                $display("%0t: unexpected result: expected none, got sample %0d",
                         $time, o_sample_out);
                fail_count++;
            end else begin
                got_due = processed_due.pop_front();
                if (o_sample_out !== got_due.smp) begin
                    $display("%0t: sample_out: expected %0d, got %0d",
                             $time, got_due.smp, o_sample_out);
                    fail_count++;
                end
                if (o_end_of_block_out !== got_due.eob) begin
                    $display("%0t: end_of_block_out: expected %0b, got %0b",
                             $time, got_due.eob, o_end_of_block_out);
                    fail_count++;
                end
                if (o_byte_keep_out !== got_due.keep) begin
                    $display("%0t: byte_keep_out: expected %0d, got %0d",
                             $time, got_due.keep, o_byte_keep_out);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        int unsigned r;
        int unsigned seg;
        foreach (echo_hist[i]) begin
            echo_hist[i] = '0;
        end

        // Directed table. Typed expectations come straight from the mode rules;
        // most echo rows lean on the predictor for the history arithmetic.
        dir_table = '{
            // reset settings: distortion, unity gain, full-scale clip
            smp_row(16'sd32767,  1'b1, 2'd3, 1'b1, 16'sd32767),
            smp_row(-16'sd32768, 1'b0, 2'd0, 1'b1, -16'sd32767),
            smp_row(16'sd0,      1'b1, 2'd1, 1'b1, 16'sd0),
            reg_row(CFG_DRIVE_GAIN, 16'd255),
            reg_row(CFG_CLIP_LEVEL, 16'd1000),
            smp_row(16'sd100,    1'b0, 2'd2, 1'b1, 16'sd1000),
            smp_row(-16'sd32768, 1'b1, 2'd3, 1'b1, -16'sd1000),
            // zero gain, then zero clip level: both silence the output
            reg_row(CFG_DRIVE_GAIN, 16'd0),
            smp_row(16'sd12345,  1'b0, 2'd1, 1'b1, 16'sd0),
            reg_row(CFG_DRIVE_GAIN, 16'd3),
            reg_row(CFG_CLIP_LEVEL, 16'd0),
            smp_row(16'sd5,      1'b0, 2'd0, 1'b1, 16'sd0),
            // bitcrusher, including counts of sixteen and above
            reg_row(CFG_EFFECT_MODE, 16'(MODE_CRUSH)),
            reg_row(CFG_CRUSH_BITS, 16'd4),
            smp_row(16'sd32767,  1'b0, 2'd3, 1'b1, 16'sd32752),
            smp_row(-16'sd1,     1'b1, 2'd2, 1'b1, -16'sd16),
            reg_row(CFG_CRUSH_BITS, 16'd16),
            smp_row(-16'sd1,     1'b0, 2'd1, 1'b1, 16'sd0),
            reg_row(CFG_CRUSH_BITS, 16'd31),
            smp_row(16'sh1234,   1'b0, 2'd0, 1'b1, 16'sd0),
            reg_row(CFG_CRUSH_BITS, 16'd15),
            smp_row(-16'sd1,     1'b1, 2'd3, 1'b1, -16'sd32768),
            reg_row(CFG_CRUSH_BITS, 16'd0),
            smp_row(16'shAAAA,   1'b0, 2'd2, 1'b1, 16'shAAAA),
            // echo over a freshly cleared history, then saturation both ways
            reg_row(CFG_EFFECT_MODE, 16'(MODE_ECHO)),
            reg_row(CFG_ECHO_GAIN, 16'h7FFF),
            smp_row(16'sd1000,   1'b0, 2'd1, 1'b1, 16'sd1000),
            smp_row(16'sd32767,  1'b0, 2'd3, 1'b0, '0),
            reg_row(CFG_ECHO_LAG, 16'd1),
            smp_row(16'sd32767,  1'b1, 2'd0, 1'b0, '0),
            reg_row(CFG_ECHO_GAIN, 16'h8000),
            smp_row(-16'sd32768, 1'b0, 2'd2, 1'b0, '0),
            // lag far past the history length
            reg_row(CFG_ECHO_LAG, 16'hFFFF),
            smp_row(-16'sd1,     1'b0, 2'd1, 1'b0, '0),
            // other echo code, small negative gain: floor rounding on the shift
            reg_row(CFG_EFFECT_MODE, 16'(MODE_ECHO_ALT)),
            reg_row(CFG_ECHO_LAG, 16'd1),
            reg_row(CFG_ECHO_GAIN, 16'hFFFF),
            smp_row(16'sd7,      1'b0, 2'd3, 1'b0, '0),
            smp_row(16'sd0,      1'b1, 2'd0, 1'b0, '0),
            // writes past the last register are ignored
            reg_row(CFG_SPARE_6, 16'hFFFF),
            reg_row(CFG_SPARE_7, 16'hFFFF),
            smp_row(16'sd100,    1'b0, 2'd2, 1'b0, '0),
            // bits above each register's width are dropped
            reg_row(CFG_EFFECT_MODE, 16'hFFFC),
            reg_row(CFG_DRIVE_GAIN, 16'hFF80),
            reg_row(CFG_CLIP_LEVEL, 16'hFFFF),
            smp_row(-16'sd300,   1'b1, 2'd1, 1'b1, -16'sd32767),
            smp_row(16'sd200,    1'b0, 2'd2, 1'b1, 16'sd25600)
        };

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (r = 0; r < DIR_ROWS; r++) begin
            if (dir_table[r].kind == ROW_REG) begin
                drain_results();
                write_reg(dir_table[r].reg_idx, dir_table[r].reg_val);
            end else begin
                send_sample(dir_table[r].smp, dir_table[r].eob, dir_table[r].keep,
                            dir_table[r].typed, dir_table[r].want);
            end
        end

        // Random part: every mode under every flow-control pattern.
        for (seg = 0; seg < 12; seg++) begin
            run_segment(75, idle_mode_t'(seg % 4), seg % 3, 1'b0);
        end
        // A long echo stretch at lag zero: the oldest entry is one never written.
        run_segment(100, IDLE_NONE, 2, 1'b1);
        for (seg = 0; seg < 4; seg++) begin
            run_segment(50, idle_mode_t'(seg), 2, 1'b0);
        end

        // Let the last results out, then watch a little longer for strays.
        drain_results();
        repeat (12) @(posedge i_clk);
        if (fail_count == 0 && processed_due.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
